FILE: hdl/rom_pkg.sv
// ----------------------------------------------------------------------------
// rom_pkg
// shared constants and types of the rms overcurrent monitor
// ----------------------------------------------------------------------------
package rom_pkg;

   localparam int WINDOW_LEN_DEF  = 30;
   localparam int MAX_SAMPLES_DEF = 65535;

   localparam int CODE_W   = 12;
   localparam int RMS_W    = 12;
   localparam int SUM_W    = 38;
   localparam int CNT_W    = 16;
   localparam int TIME_W   = 32;
   localparam int THR_W    = 12;
   localparam int RETRY_W  = 16;
   localparam int CSR_W    = 16;
   localparam int SQ_W     = 23;

   localparam logic [CODE_W-1:0] CODE_MID = 12'd2048;
   localparam logic [CODE_W-1:0] IDLE_MAG = 12'd664;

   localparam logic CSR_TRIP_THRESHOLD = 1'b0;
   localparam logic CSR_RETRY_TIME     = 1'b1;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_REPORT = 1'b1;

   // fields of one report result
   typedef struct packed {
      logic                 in_cooldown;
      logic                 trip_event;
      logic [RMS_W-1:0]     rms_c;
      logic [RMS_W-1:0]     rms_b;
      logic [RMS_W-1:0]     rms_a;
   } rsp_type;

endpackage

FILE: hdl/rms_overcurrent_monitor.sv
// ----------------------------------------------------------------------------
// rms_overcurrent_monitor
// per-phase rms current monitor with windowed overcurrent trip and cooldown
// ----------------------------------------------------------------------------
// A sample transfer keeps the block busy until all three phases are done, so
// no new sample is taken before the last is through: for each of a, b and c
// the accumulator word is read from one ram and the square formed in the same
// cycle, then added and written back in the next; the sample count is a
// register, and a sample that finds it saturated is dropped in the transfer
// cycle. A report runs through to its end before the next transfer: a shared
// serial unit divides each sum by the count (38 steps) and takes the root (19
// steps), then the peak window ram is written and summed entry by entry, and
// the accumulators and the sample count are cleared. A report whose previous
// result has not been taken yet waits before its result register for as long
// as that lasts. After reset a clearing pass over WINDOW_LEN addresses (at
// least 3) zeroes the window ram and accumulators; no item is taken during it.
module rms_overcurrent_monitor #(
   parameter int WINDOW_LEN  = rom_pkg::WINDOW_LEN_DEF,
   parameter int MAX_SAMPLES = rom_pkg::MAX_SAMPLES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // req_type
   // phase_a_code, phase_b_code, phase_c_code, driver_enabled, time_ms, pad
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rms_a, rms_b, rms_c, trip_event, in_cooldown, pad
   output logic [39:0] rsp_tdata,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [rom_pkg::CSR_W-1:0] csr_wr_data
);
   import rom_pkg::*;

   localparam int CLR_LEN = (WINDOW_LEN > 3) ? WINDOW_LEN : 3;
   localparam int WIN_AW  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int WIN_CW  = $clog2(CLR_LEN + 1);
   localparam int TOT_W   = RMS_W + WIN_CW;
   localparam int ACC_W   = SUM_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

   typedef enum logic [12:0] {
      ST_CLEAR  = 13'b0000000000001,
      ST_IDLE   = 13'b0000000000010,
      ST_SRD    = 13'b0000000000100,
      ST_SUPD   = 13'b0000000001000,
      ST_RRD    = 13'b0000000010000,
      ST_RDIV   = 13'b0000000100000,
      ST_RWAIT  = 13'b0000001000000,
      ST_WWR    = 13'b0000010000000,
      ST_WRD    = 13'b0000100000000,
      ST_WSUM   = 13'b0001000000000,
      ST_DECIDE = 13'b0010000000000,
      ST_OUT    = 13'b0100000000000,
      ST_ACLR   = 13'b1000000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [THR_W-1:0]     thr_ff, thr_in;
   logic [RETRY_W-1:0]   retry_ff, retry_in;
   logic [WIN_AW-1:0]    ptr_ff, ptr_in;
   logic [WIN_CW-1:0]    idx_ff, idx_in;
   logic [1:0]           ph_ff, ph_in;
   logic                 cool_ff, cool_in;
   logic [TIME_W-1:0]    cstart_ff, cstart_in;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic                 en_ff, en_in;
   logic [CODE_W-1:0]    code_ff [3];
   logic [CODE_W-1:0]    code_in [3];
   logic [SQ_W-1:0]      sq_ff, sq_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [RMS_W-1:0]     rms_ff [3];
   logic [RMS_W-1:0]     rms_in [3];
   logic [RMS_W-1:0]     peak_ff, peak_in;
   logic [TOT_W-1:0]     tot_ff, tot_in;
   logic                 trip_ff, trip_in;
   logic                 ovalid_ff, ovalid_in;
   rsp_type              odata_ff, odata_in;

   logic                 acc_we;
   logic [1:0]           acc_wa, acc_ra;
   logic [ACC_W-1:0]     acc_wd, acc_rd;
   logic                 win_we;
   logic [WIN_AW-1:0]    win_wa, win_ra;
   logic [RMS_W-1:0]     win_wd, win_rd;

   logic                 dv_start, dv_done;
   logic [RMS_W-1:0]     dv_root;

   logic [CODE_W-1:0]    cur_code;
   logic [CODE_W-1:0]    mag;
   logic [TIME_W-1:0]    end_time;
   logic                 do_trip;
   logic                 cool_mid;
   logic [TIME_W-1:0]    cstart_mid;

   rom_ram #(.WIDTH(ACC_W), .DEPTH(4)) u_acc (
      .clock(clock), .wr_en(acc_we), .wr_addr(acc_wa), .wr_data(acc_wd),
      .rd_addr(acc_ra), .rd_data(acc_rd)
   );

   rom_ram #(.WIDTH(RMS_W), .DEPTH(WINDOW_LEN)) u_win (
      .clock(clock), .wr_en(win_we), .wr_addr(win_wa), .wr_data(win_wd),
      .rd_addr(win_ra), .rd_data(win_rd)
   );

   rom_divsqrt u_dvs (
      .clock(clock), .reset(reset), .start(dv_start),
      .dividend(acc_rd), .divisor(cnt_ff), .done(dv_done), .root(dv_root)
   );

   // magnitude of the current of the phase under work
   always_comb begin
      cur_code = code_ff[ph_ff];
      if (!en_ff) begin
         mag = IDLE_MAG;
      end else if (cur_code >= CODE_MID) begin
         mag = cur_code - CODE_MID;
      end else begin
         mag = CODE_MID - cur_code;
      end
   end

   assign do_trip    = (tot_ff > TOT_W'(thr_ff * WINDOW_LEN)) && !cool_ff;
   assign cool_mid   = cool_ff || do_trip;
   assign cstart_mid = do_trip ? time_ff : cstart_ff;
   assign end_time   = cstart_mid + {{(TIME_W-RETRY_W){1'b0}}, retry_ff};

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      thr_in    = thr_ff;
      retry_in  = retry_ff;
      ptr_in    = ptr_ff;
      idx_in    = idx_ff;
      ph_in     = ph_ff;
      cool_in   = cool_ff;
      cstart_in = cstart_ff;
      time_in   = time_ff;
      en_in     = en_ff;
      code_in   = code_ff;
      sq_in     = sq_ff;
      cnt_in    = cnt_ff;
      rms_in    = rms_ff;
      peak_in   = peak_ff;
      tot_in    = tot_ff;
      trip_in   = trip_ff;
      ovalid_in = ovalid_ff;
      odata_in  = odata_ff;
      acc_we    = 1'b0;
      acc_wa    = ph_ff;
      acc_wd    = '0;
      acc_ra    = ph_ff;
      win_we    = 1'b0;
      win_wa    = ptr_ff;
      win_wd    = peak_ff;
      win_ra    = idx_ff[WIN_AW-1:0];
      dv_start  = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TRIP_THRESHOLD: thr_in   = csr_wr_data[THR_W-1:0];
            CSR_RETRY_TIME:     retry_in = csr_wr_data[RETRY_W-1:0];
            default: ;
         endcase
      end

      if (ovalid_ff && rsp_tready) begin
         ovalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            win_we = (idx_ff < WIN_CW'(WINDOW_LEN));
            win_wa = idx_ff[WIN_AW-1:0];
            win_wd = '0;
            acc_we = 1'b1;
            acc_wa = idx_ff[1:0];
            idx_in = idx_ff + 1'b1;
            if (idx_ff == WIN_CW'(CLR_LEN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               code_in[0] = req_tdata[11:0];
               code_in[1] = req_tdata[23:12];
               code_in[2] = req_tdata[35:24];
               en_in      = req_tdata[36];
               time_in    = req_tdata[68:37];
               ph_in      = 2'd0;
               if (req_tuser == REQ_SAMPLE) begin
                  // sample is dropped once the count is saturated
                  if (cnt_ff < MAX_CNT) begin
                     state_in = ST_SRD;
                  end
               end else begin
                  state_in = ST_RRD;
               end
            end
         end
         ST_SRD: begin
            sq_in    = SQ_W'(mag * mag);
            state_in = ST_SUPD;
         end
         ST_SUPD: begin
            acc_we = 1'b1;
            acc_wd = acc_rd + {{(ACC_W-SQ_W){1'b0}}, sq_ff};
            ph_in  = ph_ff + 1'b1;
            acc_ra = ph_ff + 1'b1;
            if (ph_ff == 2'd2) begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SRD;
            end
         end
         ST_RRD: begin
            state_in = ST_RDIV;
         end
         ST_RDIV: begin
            dv_start = 1'b1;
            state_in = ST_RWAIT;
         end
         ST_RWAIT: begin
            if (dv_done) begin
               rms_in[ph_ff] = dv_root;
               if (dv_root > peak_ff || ph_ff == 2'd0) begin
                  peak_in = dv_root;
               end
               ph_in = ph_ff + 1'b1;
               acc_ra = ph_ff + 1'b1;
               if (ph_ff == 2'd2) begin
                  state_in = ST_WWR;
               end else begin
                  state_in = ST_RRD;
               end
            end
         end
         ST_WWR: begin
            win_we   = 1'b1;
            ptr_in   = (ptr_ff == WIN_AW'(WINDOW_LEN - 1)) ? '0 : ptr_ff + 1'b1;
            idx_in   = '0;
            tot_in   = '0;
            state_in = ST_WRD;
         end
         ST_WRD: begin
            idx_in   = idx_ff + 1'b1;
            state_in = ST_WSUM;
         end
         ST_WSUM: begin
            tot_in = tot_ff + {{(TOT_W-RMS_W){1'b0}}, win_rd};
            if (idx_ff == WIN_CW'(WINDOW_LEN)) begin
               state_in = ST_DECIDE;
            end else begin
               state_in = ST_WRD;
            end
         end
         ST_DECIDE: begin
            trip_in   = do_trip;
            cool_in   = cool_mid;
            cstart_in = cstart_mid;
            if (cool_mid && (time_ff > end_time)) begin
               cool_in   = 1'b0;
               cstart_in = '0;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!ovalid_ff) begin
               ovalid_in            = 1'b1;
               odata_in.rms_a       = rms_ff[0];
               odata_in.rms_b       = rms_ff[1];
               odata_in.rms_c       = rms_ff[2];
               odata_in.trip_event  = trip_ff;
               odata_in.in_cooldown = cool_ff;
               ph_in                = 2'd0;
               state_in             = ST_ACLR;
            end
         end
         ST_ACLR: begin
            acc_we = 1'b1;
            ph_in  = ph_ff + 1'b1;
            if (ph_ff == 2'd2) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         thr_ff    <= THR_W'(1024);
         retry_ff  <= RETRY_W'(1000);
         ptr_ff    <= '0;
         idx_ff    <= '0;
         ph_ff     <= '0;
         cool_ff   <= 1'b0;
         cstart_ff <= '0;
         cnt_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         thr_ff    <= thr_in;
         retry_ff  <= retry_in;
         ptr_ff    <= ptr_in;
         idx_ff    <= idx_in;
         ph_ff     <= ph_in;
         cool_ff   <= cool_in;
         cstart_ff <= cstart_in;
         cnt_ff    <= cnt_in;
         ovalid_ff <= ovalid_in;
      end
      time_ff  <= time_in;
      en_ff    <= en_in;
      code_ff  <= code_in;
      sq_ff    <= sq_in;
      rms_ff   <= rms_in;
      peak_ff  <= peak_in;
      tot_ff   <= tot_in;
      trip_ff  <= trip_in;
      odata_ff <= odata_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {2'b00, odata_ff.in_cooldown, odata_ff.trip_event,
                        odata_ff.rms_c, odata_ff.rms_b, odata_ff.rms_a};

endmodule

FILE: hdl/rom_ram.sv
// ----------------------------------------------------------------------------
// rom_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module rom_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hdl/rom_divsqrt.sv
// ----------------------------------------------------------------------------
// rom_divsqrt
// restoring divide of a 38-bit sum by a 16-bit count, then bitwise root
// ----------------------------------------------------------------------------
module rom_divsqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rom_pkg::SUM_W-1:0]   dividend,
   input  logic [rom_pkg::CNT_W-1:0]   divisor,
   output logic                        done,
   output logic [rom_pkg::RMS_W-1:0]   root
);
   import rom_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);
   localparam int RES_W  = 19;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_SQRT = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [CNT_W:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]    den_ff, den_in;
   logic [RES_W+1:0]    sr_ff, sr_in;
   logic [RES_W-1:0]    res_ff, res_in;
   logic                done_ff, done_in;

   logic [CNT_W:0]      rem_shift;
   logic [RES_W+1:0]    sr_shift;
   logic [RES_W+1:0]    trial;

   assign rem_shift = {rem_ff[CNT_W-1:0], quo_ff[SUM_W-1]};
   assign sr_shift  = {sr_ff[RES_W-1:0], quo_ff[SUM_W-1 -: 2]};
   assign trial     = {res_ff, 2'b01};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      sr_in    = sr_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               quo_in   = dividend;
               rem_in   = '0;
               den_in   = (divisor == '0) ? CNT_W'(1) : divisor;
               step_in  = STEP_W'(SUM_W);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_shift >= {1'b0, den_ff}) begin
               rem_in = rem_shift - {1'b0, den_ff};
               quo_in = {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               sr_in    = '0;
               res_in   = '0;
               step_in  = STEP_W'(SUM_W / 2);
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            quo_in = {quo_ff[SUM_W-3:0], 2'b00};
            if (sr_shift >= trial) begin
               sr_in  = sr_shift - trial;
               res_in = {res_ff[RES_W-2:0], 1'b1};
            end else begin
               sr_in  = sr_shift;
               res_in = {res_ff[RES_W-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      sr_ff   <= sr_in;
      res_ff  <= res_in;
   end

   assign done = done_ff;
   assign root = res_ff[RMS_W-1:0];

endmodule
